[rtl/spgbf_pkg.sv]
package spgbf_pkg;

  // table and country sizes
  localparam int TABLE_ENTRIES = 1024;
  localparam int COUNTRY_COUNT = 256;

  localparam int TABLE_AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FLAG_AW   = $clog2(COUNTRY_COUNT);
  localparam int CLEAR_LEN = (TABLE_ENTRIES > COUNTRY_COUNT) ? TABLE_ENTRIES : COUNTRY_COUNT;
  localparam int CNT_W     = $clog2(CLEAR_LEN);

  // request kinds
  localparam logic [1:0] REQ_CLASSIFY = 2'd0;
  localparam logic [1:0] REQ_ENTRY    = 2'd1;
  localparam logic [1:0] REQ_FLAG     = 2'd2;

  // decision reasons
  localparam logic [2:0] RSN_NON_IP    = 3'd0;
  localparam logic [2:0] RSN_TRUNCATED = 3'd1;
  localparam logic [2:0] RSN_NO_MATCH  = 3'd2;
  localparam logic [2:0] RSN_ALLOWED   = 3'd3;
  localparam logic [2:0] RSN_BLOCKED   = 3'd4;
  localparam logic [2:0] RSN_WRITE     = 3'd5;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] IPV4_MIN_BYTES = 16'd34;
  localparam logic [15:0] IPV6_MIN_BYTES = 16'd54;
  localparam logic [7:0]  IPV4_BITS      = 8'd32;
  localparam logic [7:0]  IPV6_BITS      = 8'd128;

  // request payload, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic        country_blocked;
    logic [7:0]  country_code;
    logic [7:0]  prefix_length;
    logic        entry_is_ipv6;
    logic        entry_valid;
    logic [9:0]  entry_index;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
    logic [15:0] ether_type;
    logic [15:0] frame_length;
  } in_item_t;

  localparam int IN_DATA_W = $bits(in_item_t);

  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] matched_country;
    logic       prefix_matched;
    logic       verdict_drop;
  } out_data_t;

  localparam int OUT_DATA_W = $bits(out_data_t);

  // one prefix table word
  typedef struct packed {
    logic        valid;
    logic        is_ipv6;
    logic [7:0]  plen;
    logic [7:0]  country;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             clear;
    logic             scan;
    logic [CNT_W-1:0] idx;
    logic             flag_rd;
    logic             finish;
    logic             push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic pipe_busy;
  } dp_stat_t;

  // mask of the len leading bits of a 128-bit key
  function automatic logic [127:0] lead_mask(input logic [7:0] len);
    logic [127:0] m;
    m = '0;
    for (int j = 0; j < 128; j++) begin
      m[127-j] = (j < int'(len));
    end
    return m;
  endfunction

endpackage

[rtl/source_prefix_geo_block_filter_core.sv]
// sequence: a table or flag write, a non-ip frame or a short frame goes from the taken request
// straight to the result handoff; a lookup scans every table entry, drains the compare
// pipeline, reads the country flag and then hands off its result. throughput: one request at
// a time, the lookup reads one prefix entry a cycle from the table ram port
// reset: rst_n synchronous active low; afterwards a clearing pass zeroes every table entry
// and country flag with in_tready low
module source_prefix_geo_block_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_length, ether_type, addr_high, addr_low, entry_index, entry_valid,
  // entry_is_ipv6, prefix_length, country_code, country_blocked, zero pad
  input  logic [spgbf_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  logic [1:0]                        in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // verdict_drop, prefix_matched, matched_country, zero pad
  output logic [spgbf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // decision_reason
  output logic [2:0]                        out_tuser
);

  // command and status between sequencer and datapath
  spgbf_pkg::ctrl_cmd_t cmd;
  spgbf_pkg::dp_stat_t  stat;

  // sequencer: clearing pass, table scan, flag lookup, output handoff
  spgbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: table and flag rams, compare pipeline, best match, result register
  spgbf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // only one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.clear, cmd.scan, cmd.flag_rd, cmd.finish, cmd.push}))
    else $error("more than one datapath command at once");

  // no request taken while the compare pipeline still holds entries
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.pipe_busy)
    else $error("request taken with lookup pipeline busy");

  // a result only appears after a handoff from the sequencer
  a_push_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.push))
    else $error("result valid without a handoff");

  // a finished lookup never overwrites a result still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");
`endif

endmodule

[rtl/spgbf_ram.sv]
module spgbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/spgbf_ctrl.sv]
module spgbf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  spgbf_pkg::dp_stat_t   stat,
  output spgbf_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FLAG   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  localparam logic [spgbf_pkg::CNT_W-1:0] CLEAR_LAST =
    spgbf_pkg::CNT_W'(spgbf_pkg::CLEAR_LEN - 1);
  localparam logic [spgbf_pkg::CNT_W-1:0] SCAN_LAST =
    spgbf_pkg::CNT_W'(spgbf_pkg::TABLE_ENTRIES - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [spgbf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        out_vld_r, out_vld_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.idx     = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (cnt_r == CLEAR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = stat.need_scan ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (cnt_r == SCAN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_FLAG;
        end
      end
      ST_FLAG: begin
        cmd.flag_rd = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_vld_nxt = cmd.push | (out_vld_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

[rtl/spgbf_dp.sv]
module spgbf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [spgbf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic [spgbf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                        out_tuser,
  input  spgbf_pkg::ctrl_cmd_t              cmd,
  output spgbf_pkg::dp_stat_t               stat
);

  spgbf_pkg::in_item_t   item;
  spgbf_pkg::tbl_entry_t tbl_wdata, tbl_rd;
  logic [spgbf_pkg::TBL_W-1:0]    tbl_rdata;
  logic [spgbf_pkg::TABLE_AW-1:0] tbl_waddr;
  logic                           tbl_we;
  logic [spgbf_pkg::FLAG_AW-1:0]  flag_waddr;
  logic                           flag_we, flag_wdata, flag_rdata;

  logic is_v4, is_v6, short_eth, short_ip, entry_ok, cc_ok;

  // item under lookup
  logic [127:0] key_r;
  logic         v6_r;

  // scan pipeline
  logic         s1_vld_r, s2_vld_r;
  logic         s2_hit_r;
  logic [7:0]   s2_len_r, s2_cc_r;
  logic [127:0] ekey;
  logic [7:0]   max_len;
  logic         hit;

  logic         best_found_r;
  logic [7:0]   best_len_r, best_cc_r;

  logic         res_drop_r, res_match_r;
  logic [2:0]   res_reason_r;
  logic [7:0]   res_cc_r;
  logic         blocked;

  spgbf_pkg::out_data_t out_data_r;
  logic [2:0]           out_reason_r;

  assign item = spgbf_pkg::in_item_t'(in_tdata);

  assign is_v4     = (item.ether_type == spgbf_pkg::ETYPE_IPV4);
  assign is_v6     = (item.ether_type == spgbf_pkg::ETYPE_IPV6);
  assign short_eth = (item.frame_length < spgbf_pkg::ETH_HDR_BYTES);
  assign short_ip  = is_v6 ? (item.frame_length < spgbf_pkg::IPV6_MIN_BYTES)
                           : (item.frame_length < spgbf_pkg::IPV4_MIN_BYTES);
  assign entry_ok  = (32'(item.entry_index) < 32'(spgbf_pkg::TABLE_ENTRIES));
  assign cc_ok     = (32'(item.country_code) < 32'(spgbf_pkg::COUNTRY_COUNT));

  assign stat.need_scan = (in_tuser == spgbf_pkg::REQ_CLASSIFY) && !short_eth &&
                          (is_v4 || is_v6) && !short_ip;
  assign stat.pipe_busy = s1_vld_r | s2_vld_r;

  // table write port: clearing pass or entry write
  always_comb begin
    tbl_wdata = '0;
    if (cmd.clear) begin
      tbl_we    = (32'(cmd.idx) < 32'(spgbf_pkg::TABLE_ENTRIES));
      tbl_waddr = spgbf_pkg::TABLE_AW'(cmd.idx);
    end else begin
      tbl_we            = cmd.accept && (in_tuser == spgbf_pkg::REQ_ENTRY) && entry_ok;
      tbl_waddr         = spgbf_pkg::TABLE_AW'(item.entry_index);
      tbl_wdata.valid   = item.entry_valid;
      tbl_wdata.is_ipv6 = item.entry_is_ipv6;
      tbl_wdata.plen    = item.prefix_length;
      tbl_wdata.country = item.country_code;
      tbl_wdata.addr_hi = item.addr_high;
      tbl_wdata.addr_lo = item.addr_low;
    end
  end

  // flag write port
  always_comb begin
    if (cmd.clear) begin
      flag_we    = (32'(cmd.idx) < 32'(spgbf_pkg::COUNTRY_COUNT));
      flag_waddr = spgbf_pkg::FLAG_AW'(cmd.idx);
      flag_wdata = 1'b0;
    end else begin
      flag_we    = cmd.accept && (in_tuser == spgbf_pkg::REQ_FLAG) && cc_ok;
      flag_waddr = spgbf_pkg::FLAG_AW'(item.country_code);
      flag_wdata = item.country_blocked;
    end
  end

  spgbf_ram #(
    .WIDTH (spgbf_pkg::TBL_W),
    .DEPTH (spgbf_pkg::TABLE_ENTRIES)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (cmd.scan),
    .raddr (spgbf_pkg::TABLE_AW'(cmd.idx)),
    .rdata (tbl_rdata)
  );

  spgbf_ram #(
    .WIDTH (1),
    .DEPTH (spgbf_pkg::COUNTRY_COUNT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (cmd.flag_rd),
    .raddr (spgbf_pkg::FLAG_AW'(best_cc_r)),
    .rdata (flag_rdata)
  );

  // entry compare, ipv4 keys sit in the top 32 bits
  assign tbl_rd  = spgbf_pkg::tbl_entry_t'(tbl_rdata);
  assign ekey    = v6_r ? {tbl_rd.addr_hi, tbl_rd.addr_lo} : {tbl_rd.addr_lo[31:0], 96'd0};
  assign max_len = v6_r ? spgbf_pkg::IPV6_BITS : spgbf_pkg::IPV4_BITS;
  assign hit     = tbl_rd.valid && (tbl_rd.is_ipv6 == v6_r) && (tbl_rd.plen <= max_len) &&
                   (((key_r ^ ekey) & spgbf_pkg::lead_mask(tbl_rd.plen)) == 128'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.scan;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_hit_r <= hit;
    s2_len_r <= tbl_rd.plen;
    s2_cc_r  <= tbl_rd.country;
  end

  // key capture and running best match
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v6_r         <= is_v6;
      key_r        <= is_v6 ? {item.addr_high, item.addr_low} : {item.addr_low[31:0], 96'd0};
      best_found_r <= 1'b0;
      best_len_r   <= '0;
      best_cc_r    <= '0;
    end else if (s2_vld_r && s2_hit_r && (!best_found_r || (s2_len_r > best_len_r))) begin
      best_found_r <= 1'b1;
      best_len_r   <= s2_len_r;
      best_cc_r    <= s2_cc_r;
    end
  end

  assign blocked = flag_rdata && (32'(best_cc_r) < 32'(spgbf_pkg::COUNTRY_COUNT));

  // result of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_drop_r   <= 1'b0;
      res_reason_r <= spgbf_pkg::RSN_WRITE;
      res_match_r  <= 1'b0;
      res_cc_r     <= '0;
      if (in_tuser == spgbf_pkg::REQ_CLASSIFY) begin
        if (short_eth) begin
          res_drop_r   <= 1'b1;
          res_reason_r <= spgbf_pkg::RSN_TRUNCATED;
        end else if (!is_v4 && !is_v6) begin
          res_reason_r <= spgbf_pkg::RSN_NON_IP;
        end else if (short_ip) begin
          res_drop_r   <= 1'b1;
          res_reason_r <= spgbf_pkg::RSN_TRUNCATED;
        end
      end
    end else if (cmd.finish) begin
      res_match_r <= best_found_r;
      res_cc_r    <= best_found_r ? best_cc_r : 8'd0;
      res_drop_r  <= best_found_r && blocked;
      if (!best_found_r) begin
        res_reason_r <= spgbf_pkg::RSN_NO_MATCH;
      end else if (blocked) begin
        res_reason_r <= spgbf_pkg::RSN_BLOCKED;
      end else begin
        res_reason_r <= spgbf_pkg::RSN_ALLOWED;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.pad             <= '0;
      out_data_r.matched_country <= res_cc_r;
      out_data_r.prefix_matched  <= res_match_r;
      out_data_r.verdict_drop    <= res_drop_r;
      out_reason_r               <= res_reason_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_reason_r;

endmodule
